FILE: src/cor_pkg.sv
// Shared types and constants for the column order restore block.
package cor_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int CNT_W           = 7;
    localparam int CMD_W           = 2;
    localparam int BYTE_W          = 8;
    localparam int COL_W           = 6;
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;

    localparam logic [CMD_W-1:0] CMD_REF     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ROW     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic REG_COLUMN_COUNT = 1'b0;

    typedef enum logic [1:0] {
        PH_REF,
        PH_ROWS,
        PH_HALT
    } t_phase;

    typedef enum logic [3:0] {
        B_IDLE,
        A_IADDR,
        A_ICAP,
        A_JADDR,
        A_JCMP,
        A_WR,
        M_TADDR,
        M_TCAP,
        M_WCAP,
        M_JADDR,
        M_JCMP,
        G_ADDR,
        G_MAP,
        G_OUT
    } t_bstate;

    typedef struct packed {
        logic valid;
        logic build;
    } t_job;

    typedef struct packed {
        logic busy;
        logic take;
        logic map_built;
        logic error;
    } t_bstat;

endpackage

FILE: src/column_order_restore.sv
// Top level of the column order restore block: register port, stores, front and back.
//
// Usage: set column_count through the APB port (register 0, byte address 0), then
// issue transactions on start/i_cmd/i_value while busy is low. Command 0 loads one
// byte of the reference row, command 1 loads one byte of a matrix row, command 2
// restarts and expects a new reference row. When a matrix row completes, busy rises
// while the back end works. For the first row it ranks the reference bytes over the
// reference store read port, then matches them against the row over the row store
// read port, then gathers the row. Every row is gathered through the G_ADDR, G_MAP
// and G_OUT states per output byte, set by the chained map and row store reads, and
// busy stays high while it is emitted. Each result is shown for one cycle with
// o_strobe high; the receiver cannot stall, so results are never held. A reference
// value with no match gives one error transaction (o_status and o_row_last high)
// and the block ignores bytes until a restart. Reset restores column_count to the
// maximum, returns to loading the reference row, and marks the map as not built; a
// register write acts as a restart as well.
module column_order_restore #(
    parameter int MAX_COLUMNS = cor_pkg::MAX_COLUMNS_DEF,
    localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cor_pkg::CMD_W-1:0]    i_cmd,
    input  logic [cor_pkg::BYTE_W-1:0]   i_value,
    output logic                         o_strobe,
    output logic [cor_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [cor_pkg::COL_W-1:0]    o_out_column,
    output logic                         o_row_last,
    output logic                         o_status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cor_pkg::ADDR_W-1:0]   paddr,
    input  logic [cor_pkg::DATA_W-1:0]   pwdata,
    output logic [cor_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    logic [cor_pkg::CNT_W-1:0]  r_count;
    logic [cor_pkg::CNT_W-1:0]  n_count;
    logic [cor_pkg::CNT_W-1:0]  wr_val;
    logic                       cfg_wr;
    logic [IW-1:0]              last_idx;
    cor_pkg::t_bstat            bstat;
    cor_pkg::t_job              job;
    logic                       ref_we;
    logic                       row_we;
    logic [IW-1:0]              waddr;
    logic [IW-1:0]              ref_raddr;
    logic [IW-1:0]              row_raddr;
    logic [IW-1:0]              map_raddr;
    logic [cor_pkg::BYTE_W-1:0] ref_rdata;
    logic [cor_pkg::BYTE_W-1:0] row_rdata;
    logic [IW-1:0]              map_rdata;
    logic                       map_we;
    logic [IW-1:0]              map_waddr;
    logic [IW-1:0]              map_wdata;

    // Register write: only the column count exists; addresses with bit 2 set are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == cor_pkg::REG_COLUMN_COUNT);
    assign wr_val = pwdata[cor_pkg::CNT_W-1:0];
    assign prdata = (paddr[2] == cor_pkg::REG_COLUMN_COUNT)
                    ? cor_pkg::DATA_W'(r_count) : '0;

    // The written count is saturated into the legal column range.
    always_comb begin
        if (wr_val == '0) begin
            n_count = cor_pkg::CNT_W'(1);
        end else if (wr_val > cor_pkg::CNT_W'(MAX_COLUMNS)) begin
            n_count = cor_pkg::CNT_W'(MAX_COLUMNS);
        end else begin
            n_count = wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= cor_pkg::CNT_W'(MAX_COLUMNS);
        end else if (cfg_wr) begin
            r_count <= n_count;
        end
    end

    // Index of the last column, used by both halves for end of row detection.
    assign last_idx = IW'(r_count - 1'b1);

    cor_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .i_last_idx (last_idx),
        .i_cfg_wr   (cfg_wr),
        .i_bstat    (bstat),
        .o_busy     (busy),
        .o_ref_we   (ref_we),
        .o_row_we   (row_we),
        .o_waddr    (waddr),
        .o_job      (job)
    );

    cor_ram #(.WIDTH(cor_pkg::BYTE_W), .DEPTH(MAX_COLUMNS)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    cor_ram #(.WIDTH(cor_pkg::BYTE_W), .DEPTH(MAX_COLUMNS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // The map store first holds the sorted reference order, then the source columns.
    cor_ram #(.WIDTH(IW), .DEPTH(MAX_COLUMNS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    cor_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_last_idx   (last_idx),
        .i_job        (job),
        .o_bstat      (bstat),
        .o_ref_raddr  (ref_raddr),
        .i_ref_rdata  (ref_rdata),
        .o_row_raddr  (row_raddr),
        .i_row_rdata  (row_rdata),
        .o_map_raddr  (map_raddr),
        .i_map_rdata  (map_rdata),
        .o_map_we     (map_we),
        .o_map_waddr  (map_waddr),
        .o_map_wdata  (map_wdata),
        .o_strobe     (o_strobe),
        .o_out_byte   (o_out_byte),
        .o_out_column (o_out_column),
        .o_row_last   (o_row_last),
        .o_status     (o_status)
    );

endmodule

FILE: src/cor_ram.sv
// Generic single write port, single read port RAM with registered read data.
module cor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: src/cor_front.sv
// Front end: accepts commands, fills the reference and row stores, queues row jobs.
module cor_front #(
    parameter int MAX_COLUMNS = cor_pkg::MAX_COLUMNS_DEF,
    localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cor_pkg::CMD_W-1:0]   i_cmd,
    input  logic [cor_pkg::BYTE_W-1:0]  i_value,
    input  logic [IW-1:0]               i_last_idx,
    input  logic                        i_cfg_wr,
    input  cor_pkg::t_bstat             i_bstat,
    output logic                        o_busy,
    output logic                        o_ref_we,
    output logic                        o_row_we,
    output logic [IW-1:0]               o_waddr,
    output cor_pkg::t_job               o_job
);

    cor_pkg::t_phase r_phase;
    logic [IW-1:0]   r_fill;
    logic            r_map_ready;
    cor_pkg::t_job   r_job;
    logic            accept;
    logic            fill_last;

    assign o_busy    = r_job.valid | i_bstat.busy;
    assign accept    = i_start & ~o_busy;
    assign fill_last = (r_fill == i_last_idx);
    assign o_waddr   = r_fill;
    assign o_job     = r_job;
    assign o_ref_we  = accept & (i_cmd == cor_pkg::CMD_REF) & (r_phase == cor_pkg::PH_REF);
    assign o_row_we  = accept & (i_cmd == cor_pkg::CMD_ROW) & (r_phase == cor_pkg::PH_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cor_pkg::PH_REF;
            r_fill      <= '0;
            r_map_ready <= 1'b0;
            r_job       <= '0;
        end else begin
            if (i_bstat.take) begin
                r_job.valid <= 1'b0;
            end
            if (i_bstat.map_built) begin
                r_map_ready <= 1'b1;
            end
            if (i_bstat.error) begin
                r_phase <= cor_pkg::PH_HALT;
            end
            if (i_cfg_wr || (accept && i_cmd == cor_pkg::CMD_RESTART)) begin
                r_phase     <= cor_pkg::PH_REF;
                r_fill      <= '0;
                r_map_ready <= 1'b0;
            end else if (o_ref_we) begin
                if (fill_last) begin
                    r_fill  <= '0;
                    r_phase <= cor_pkg::PH_ROWS;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (o_row_we) begin
                if (fill_last) begin
                    r_fill      <= '0;
                    r_job.valid <= 1'b1;
                    r_job.build <= ~r_map_ready;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

endmodule

FILE: src/cor_back.sv
// Back end: builds the column map from the first row and gathers restored rows.
module cor_back #(
    parameter int MAX_COLUMNS = cor_pkg::MAX_COLUMNS_DEF,
    localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [IW-1:0]               i_last_idx,
    input  cor_pkg::t_job               i_job,
    output cor_pkg::t_bstat             o_bstat,
    output logic [IW-1:0]               o_ref_raddr,
    input  logic [cor_pkg::BYTE_W-1:0]  i_ref_rdata,
    output logic [IW-1:0]               o_row_raddr,
    input  logic [cor_pkg::BYTE_W-1:0]  i_row_rdata,
    output logic [IW-1:0]               o_map_raddr,
    input  logic [IW-1:0]               i_map_rdata,
    output logic                        o_map_we,
    output logic [IW-1:0]               o_map_waddr,
    output logic [IW-1:0]               o_map_wdata,
    output logic                        o_strobe,
    output logic [cor_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [cor_pkg::COL_W-1:0]   o_out_column,
    output logic                        o_row_last,
    output logic                        o_status
);

    cor_pkg::t_bstate         r_state;
    cor_pkg::t_bstate         n_state;
    logic [IW-1:0]            r_i;
    logic [IW-1:0]            r_j;
    logic [IW-1:0]            r_t;
    logic [IW-1:0]            r_rank;
    logic [cor_pkg::BYTE_W-1:0] r_vi;
    logic [cor_pkg::BYTE_W-1:0] r_want;
    logic [MAX_COLUMNS-1:0]   r_used;
    logic                     i_last;
    logic                     j_last;
    logic                     t_last;
    logic                     hit;
    logic                     below;

    assign i_last = (r_i == i_last_idx);
    assign j_last = (r_j == i_last_idx);
    assign t_last = (r_t == i_last_idx);
    assign hit    = ~r_used[r_j] & (i_row_rdata == r_want);
    // Rank counts smaller values, and equal values at a lower reference index.
    assign below  = (i_ref_rdata < r_vi) || ((i_ref_rdata == r_vi) && (r_j < r_i));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cor_pkg::B_IDLE: begin
                if (i_job.valid) begin
                    n_state = i_job.build ? cor_pkg::A_IADDR : cor_pkg::G_ADDR;
                end
            end
            cor_pkg::A_IADDR: n_state = cor_pkg::A_ICAP;
            cor_pkg::A_ICAP:  n_state = cor_pkg::A_JADDR;
            cor_pkg::A_JADDR: n_state = cor_pkg::A_JCMP;
            cor_pkg::A_JCMP:  n_state = j_last ? cor_pkg::A_WR : cor_pkg::A_JADDR;
            cor_pkg::A_WR:    n_state = i_last ? cor_pkg::M_TADDR : cor_pkg::A_IADDR;
            cor_pkg::M_TADDR: n_state = cor_pkg::M_TCAP;
            cor_pkg::M_TCAP:  n_state = cor_pkg::M_WCAP;
            cor_pkg::M_WCAP:  n_state = cor_pkg::M_JADDR;
            cor_pkg::M_JADDR: n_state = cor_pkg::M_JCMP;
            cor_pkg::M_JCMP: begin
                if (hit) begin
                    n_state = t_last ? cor_pkg::G_ADDR : cor_pkg::M_TADDR;
                end else begin
                    n_state = j_last ? cor_pkg::B_IDLE : cor_pkg::M_JADDR;
                end
            end
            cor_pkg::G_ADDR:  n_state = cor_pkg::G_MAP;
            cor_pkg::G_MAP:   n_state = cor_pkg::G_OUT;
            cor_pkg::G_OUT:   n_state = t_last ? cor_pkg::B_IDLE : cor_pkg::G_ADDR;
            default:          n_state = cor_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_bstat.busy      = (r_state != cor_pkg::B_IDLE);
        o_bstat.take      = (r_state == cor_pkg::B_IDLE) & i_job.valid;
        o_bstat.map_built = 1'b0;
        o_bstat.error     = 1'b0;
        o_ref_raddr       = r_j;
        o_row_raddr       = r_j;
        o_map_raddr       = r_t;
        o_map_we          = 1'b0;
        o_map_waddr       = r_t;
        o_map_wdata       = r_j;
        o_strobe          = 1'b0;
        o_out_byte        = '0;
        o_out_column      = '0;
        o_row_last        = 1'b0;
        o_status          = 1'b0;
        unique case (r_state)
            cor_pkg::A_IADDR: o_ref_raddr = r_i;
            cor_pkg::A_WR: begin
                o_map_we    = 1'b1;
                o_map_waddr = r_rank;
                o_map_wdata = r_i;
            end
            cor_pkg::M_TCAP: o_ref_raddr = i_map_rdata;
            cor_pkg::M_JCMP: begin
                if (hit) begin
                    o_map_we          = 1'b1;
                    o_bstat.map_built = t_last;
                end else if (j_last) begin
                    o_bstat.error = 1'b1;
                    o_strobe      = 1'b1;
                    o_row_last    = 1'b1;
                    o_status      = 1'b1;
                end
            end
            cor_pkg::G_MAP: o_row_raddr = i_map_rdata;
            cor_pkg::G_OUT: begin
                o_strobe     = 1'b1;
                o_out_byte   = i_row_rdata;
                o_out_column = cor_pkg::COL_W'(r_t);
                o_row_last   = t_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cor_pkg::B_IDLE;
            r_used  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_t     <= '0;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                cor_pkg::B_IDLE: begin
                    r_i <= '0;
                    r_t <= '0;
                end
                cor_pkg::A_ICAP: begin
                    r_vi   <= i_ref_rdata;
                    r_j    <= '0;
                    r_rank <= '0;
                end
                cor_pkg::A_JCMP: begin
                    if (below) begin
                        r_rank <= r_rank + 1'b1;
                    end
                    r_j <= r_j + 1'b1;
                end
                cor_pkg::A_WR: begin
                    r_i <= r_i + 1'b1;
                    if (i_last) begin
                        r_used <= '0;
                        r_t    <= '0;
                    end
                end
                cor_pkg::M_WCAP: begin
                    r_want <= i_ref_rdata;
                    r_j    <= '0;
                end
                cor_pkg::M_JCMP: begin
                    if (hit) begin
                        r_used[r_j] <= 1'b1;
                        r_t         <= t_last ? '0 : r_t + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                cor_pkg::G_OUT: r_t <= r_t + 1'b1;
                default: ;
            endcase
        end
    end

endmodule
